// File: hdl/fed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_pkg
// Shared constants and types of the feedback echo delay block.
// ----------------------------------------------------------------------------
package fed_pkg;

	// delay store geometry
	localparam int DEPTH     = 65536;
	localparam int CHANNELS  = 2;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_DEPTH = CHANNELS * DEPTH;
	localparam int MAW       = $clog2(MEM_DEPTH);

	// sample and gain format
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int Q_ONE    = 32768;

	// configuration registers
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] REG_DELAY_SAMPLES = 2'd0;
	localparam logic [CFG_IW-1:0] REG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_IW-1:0] REG_WET_MIX       = 2'd2;

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       chan;
		logic                       last;
	} fed_result_t;

	typedef struct packed {
		logic [OQ_CW-1:0] count;
		logic             empty;
	} fed_oq_status_t;

endpackage

// File: hdl/fed_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module fed_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/fed_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_outq
// Small result queue between the processing pipeline and the output stream.
// ----------------------------------------------------------------------------
module fed_outq
	import fed_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fed_result_t    push_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fed_result_t    out_data,
	output fed_oq_status_t status
);

	fed_result_t      slot_q [OQ_DEPTH];
	logic [OQ_PW-1:0] rd_ptr_q;
	logic [OQ_PW-1:0] wr_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             pop;

	assign out_valid    = (count_q != '0);
	assign out_data     = slot_q[rd_ptr_q];
	assign pop          = out_valid && out_ready;
	assign status.count = count_q;
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/feedback_echo_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Per-channel feedback echo: circular delay store in RAM, dry/wet output mix.
// ----------------------------------------------------------------------------
//  channel   signals                     payload
//  cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//  s_axis    s_axis_tvalid / tready      tdata sample_in, tuser chan_sel,
//                                        tlast block_end
//  m_axis    m_axis_tvalid / tready      tdata sample_out, tuser chan_out,
//                                        tlast block_end_out
//
//  one sample per cycle on any channel mix at any delay; the feedback loop
//  (store read, forward mux, gain multiply, round, write back) closes in stage 1
//  a result passes stage 1, stage 2 and the result queue before it is valid on
//  m_axis; input is held off only when the four-entry result queue plus in-flight
//  work is full; no clearing pass after reset: a written-range mark per channel
//  makes never-written store entries read as zero; cfg writes always taken
// ----------------------------------------------------------------------------
module feedback_echo_delay
	import fed_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [15:0]         s_axis_tdata,   // [15:0] sample_in
	input  logic                s_axis_tuser,   // [0] chan_sel
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,   // [15:0] sample_out
	output logic                m_axis_tuser,   // [0] chan_out
	output logic                m_axis_tlast
);

	localparam int XW = ((AW > 16) ? AW : 16) + 1;

	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [32:0] acc);
		logic signed [32:0] t;
		logic signed [17:0] r;
		t = acc + 33'sd16384;
		r = $signed(t[32:15]);
		if (r > 18'sd32767) begin
			return 16'sh7fff;
		end else if (r < -18'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	// configuration registers
	logic [GAIN_W-1:0] delay_q;
	logic [GAIN_W-1:0] fb_gain_q;
	logic [GAIN_W-1:0] wet_mix_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= 16'd24000;
			fb_gain_q <= 16'd16384;
			wet_mix_q <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELAY_SAMPLES: delay_q   <= cfg_data;
				REG_FEEDBACK_GAIN: fb_gain_q <= cfg_data;
				REG_WET_MIX:       wet_mix_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped gains and delay
	logic [GAIN_W-1:0] fb_g;
	logic [GAIN_W-1:0] wet_g;
	logic [GAIN_W-1:0] dry_g;
	logic [XW-1:0]     dly_x;
	logic [AW:0]       dly_e;

	always_comb begin
		fb_g  = (fb_gain_q > GAIN_W'(Q_ONE)) ? GAIN_W'(Q_ONE) : fb_gain_q;
		wet_g = (wet_mix_q > GAIN_W'(Q_ONE)) ? GAIN_W'(Q_ONE) : wet_mix_q;
		dry_g = GAIN_W'(Q_ONE) - wet_g;
		dly_x = XW'(delay_q);
		if (dly_x == '0) begin
			dly_x = XW'(1);
		end else if (dly_x > XW'(DEPTH - 1)) begin
			dly_x = XW'(DEPTH - 1);
		end
		dly_e = {1'b0, dly_x[AW-1:0]};
	end

	// request side: address generation
	fed_oq_status_t   oq_st;
	logic [OQ_CW:0]   occupancy;
	logic             in_acc;
	logic [CW-1:0]    ch_in;
	logic [AW-1:0]    wp_q [CHANNELS];
	logic             wrap_q [CHANNELS];
	logic [AW-1:0]    wp_cur;
	logic [AW-1:0]    wp_next;
	logic [AW:0]      rp_x;
	logic [AW-1:0]    rp;
	logic [MAW-1:0]   base;
	logic [MAW-1:0]   raddr;
	logic [MAW-1:0]   waddr_in;
	logic             fill_in;

	logic v_s1;
	logic v_s2;

	assign occupancy     = (OQ_CW + 1)'(oq_st.count) + (OQ_CW + 1)'(v_s1)
		+ (OQ_CW + 1)'(v_s2);
	assign s_axis_tready = (occupancy < (OQ_CW + 1)'(OQ_DEPTH));
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		ch_in    = (CHANNELS > 1) ? CW'(s_axis_tuser) : '0;
		wp_cur   = wp_q[ch_in];
		wp_next  = (wp_cur == AW'(DEPTH - 1)) ? '0 : wp_cur + 1'b1;
		if ({1'b0, wp_cur} >= dly_e) begin
			rp_x = {1'b0, wp_cur} - dly_e;
		end else begin
			rp_x = {1'b0, wp_cur} + (AW + 1)'(DEPTH) - dly_e;
		end
		rp       = rp_x[AW-1:0];
		base     = (ch_in != '0) ? MAW'(DEPTH) : '0;
		raddr    = base + MAW'(rp);
		waddr_in = base + MAW'(wp_cur);
		// entry holds data once this channel wrapped or wrote past it
		fill_in  = wrap_q[ch_in] || (rp < wp_cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]   <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else if (in_acc) begin
			wp_q[ch_in] <= wp_next;
			if (wp_cur == AW'(DEPTH - 1)) begin
				wrap_q[ch_in] <= 1'b1;
			end
		end
	end

	// stage 1: store data back, feedback update and mix products
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       chan_s1;
	logic                       last_s1;
	logic [MAW-1:0]             raddr_s1;
	logic [MAW-1:0]             waddr_s1;
	logic                       fill_s1;
	logic [SAMPLE_W-1:0]        rdata;

	logic                       fwd_v_q;
	logic [MAW-1:0]             fwd_addr_q;
	logic signed [SAMPLE_W-1:0] fwd_data_q;

	logic                       fwd_hit;
	logic signed [SAMPLE_W-1:0] d_s1;
	logic signed [32:0]         p_fb;
	logic signed [32:0]         acc_fb;
	logic signed [SAMPLE_W-1:0] store_val;
	logic signed [32:0]         p_dry;
	logic signed [32:0]         p_wet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1     <= $signed(s_axis_tdata);
			chan_s1  <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
			raddr_s1 <= raddr;
			waddr_s1 <= waddr_in;
			fill_s1  <= fill_in;
		end
	end

	fed_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (v_s1),
		.waddr (waddr_s1),
		.wdata (store_val),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		// the write of the previous cycle is not yet visible to this read
		fwd_hit = fwd_v_q && (fwd_addr_q == raddr_s1);
		if (fwd_hit) begin
			d_s1 = fwd_data_q;
		end else if (fill_s1) begin
			d_s1 = $signed(rdata);
		end else begin
			d_s1 = '0;
		end
		p_fb      = d_s1 * $signed({1'b0, fb_g});
		acc_fb    = {{2{x_s1[SAMPLE_W-1]}}, x_s1, 15'b0} + p_fb;
		store_val = round_sat(acc_fb);
		p_dry     = x_s1 * $signed({1'b0, dry_g});
		p_wet     = d_s1 * $signed({1'b0, wet_g});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fwd_addr_q <= waddr_s1;
			fwd_data_q <= store_val;
		end
	end

	// stage 2: output sum, round, saturate, into the result queue
	logic signed [32:0] p_dry_s2;
	logic signed [32:0] p_wet_s2;
	logic               chan_s2;
	logic               last_s2;
	fed_result_t        res_s2;
	fed_result_t        oq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			p_dry_s2 <= p_dry;
			p_wet_s2 <= p_wet;
			chan_s2  <= chan_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		res_s2.sample = round_sat(p_dry_s2 + p_wet_s2);
		res_s2.chan   = chan_s2;
		res_s2.last   = last_s2;
	end

	fed_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (res_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (oq_data),
		.status    (oq_st)
	);

	assign m_axis_tdata = oq_data.sample;
	assign m_axis_tuser = oq_data.chan;
	assign m_axis_tlast = oq_data.last;

	a_stage1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1) else $error("accepted request did not enter stage 1");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2) else $error("stage 1 item did not advance to stage 2");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (oq_st.count < OQ_CW'(OQ_DEPTH)))
		else $error("result pushed into a full queue");

	a_fwd_written: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && fwd_hit) |-> fill_s1)
		else $error("forwarded entry marked as never written");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ((wp_cur <= AW'(DEPTH - 1)) && (rp <= AW'(DEPTH - 1))))
		else $error("store index out of range");

endmodule
